FILE: src/qpe_pkg.sv
// shared types, constants and helpers for the quoted-printable encoder
package qpe_pkg;

    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam logic [7:0]  LIMIT_RESET   = 8'd76;

    localparam logic [7:0]  CH_EQUALS     = 8'h3D;
    localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CH_TAB        = 8'h09;
    localparam logic [7:0]  CH_SPACE      = 8'h20;
    localparam logic [7:0]  CH_PLAIN_LO   = 8'd32;
    localparam logic [7:0]  CH_PLAIN_MID  = 8'd60;
    localparam logic [7:0]  CH_PLAIN_HI   = 8'd62;
    localparam logic [7:0]  CH_PLAIN_TOP  = 8'd126;
    localparam logic [7:0]  LEN_MAX       = 8'd255;

    // one classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       brk;     // soft break goes first
        logic       quoted;  // byte goes out as =XY
    } qpe_cmd_t;

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_char = 8'h30 + ext;
        end else begin
            hex_char = 8'h37 + ext;
        end
    endfunction

endpackage

FILE: src/qpe_front.sv
// front end: holds the line limit and line state, classifies each input word
module qpe_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // data_byte
    input  logic             s_axis_tlast,   // end_of_message
    output logic             push,
    input  logic             push_ready,
    output qpe_pkg::qpe_cmd_t push_cmd
);
    import qpe_pkg::*;

    logic [7:0] limit_reg, limit_next;
    logic [7:0] len_reg, len_next;
    logic       blank_reg, blank_next;

    logic       simple;
    logic       brk;
    logic       accept;
    logic [8:0] len_plus3;
    logic [8:0] grown;
    logic [7:0] base_len;

    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;
    assign push          = accept;

    always_comb begin
        simple = ((s_axis_tdata >= CH_PLAIN_LO) && (s_axis_tdata <= CH_PLAIN_MID)) ||
                 ((s_axis_tdata >= CH_PLAIN_HI) && (s_axis_tdata <= CH_PLAIN_TOP)) ||
                 (s_axis_tdata == CH_TAB) || (s_axis_tdata == CH_NEWLINE);
        len_plus3 = {1'b0, len_reg} + 9'd3;
        brk = (len_reg >= limit_reg) ||
              ((s_axis_tdata == CH_NEWLINE) && blank_reg) ||
              (!simple && (len_plus3 >= {1'b0, limit_reg}));
        base_len = brk ? 8'd0 : len_reg;
        grown = {1'b0, base_len} + (simple ? 9'd1 : 9'd3);

        push_cmd.data   = s_axis_tdata;
        push_cmd.brk    = brk;
        push_cmd.quoted = !simple;

        limit_next = cfg_we ? cfg_wdata : limit_reg;
        len_next   = len_reg;
        blank_next = blank_reg;
        if (accept) begin
            len_next   = grown[8] ? LEN_MAX : grown[7:0];
            blank_next = simple && ((s_axis_tdata == CH_SPACE) || (s_axis_tdata == CH_TAB));
            if (simple && (s_axis_tdata == CH_NEWLINE)) begin
                len_next = 8'd0;
            end
            if (s_axis_tlast) begin
                len_next   = 8'd0;
                blank_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            len_reg   <= 8'd0;
            blank_reg <= 1'b0;
        end else begin
            limit_reg <= limit_next;
            len_reg   <= len_next;
            blank_reg <= blank_next;
        end
    end

endmodule

FILE: src/qpe_queue.sv
// short queue of classified words between front and back
module qpe_queue #(
    parameter int unsigned DEPTH = qpe_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    output logic              push_ready,
    input  qpe_pkg::qpe_cmd_t push_cmd,
    output logic              head_valid,
    input  logic              pop,
    output qpe_pkg::qpe_cmd_t head_cmd
);
    import qpe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qpe_cmd_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: src/qpe_emit.sv
// back end: expands each classified word into output characters
module qpe_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  qpe_pkg::qpe_cmd_t head_cmd,
    output logic              pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // out_byte
    output logic              m_axis_tlast    // out_last
);
    import qpe_pkg::*;

    typedef enum logic [4:0] {
        S_HEAD   = 5'b00001,
        S_BRK_NL = 5'b00010,
        S_BODY   = 5'b00100,
        S_HEX_HI = 5'b01000,
        S_HEX_LO = 5'b10000
    } emit_state_t;

    emit_state_t state_reg, state_next, state_step;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        advance;
    logic [7:0]  char_c;
    logic        last_c;
    logic        done_c;

    assign advance       = head_valid && (!m_tvalid_reg || m_axis_tready);
    assign pop           = advance && done_c;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

    always_comb begin
        char_c     = head_cmd.data;
        last_c     = 1'b0;
        done_c     = 1'b0;
        state_step = S_HEAD;
        unique case (state_reg)
            S_HEAD: begin
                if (head_cmd.brk) begin
                    char_c     = CH_EQUALS;
                    state_step = S_BRK_NL;
                end else if (head_cmd.quoted) begin
                    char_c     = CH_EQUALS;
                    state_step = S_HEX_HI;
                end else begin
                    last_c = 1'b1;
                    done_c = 1'b1;
                end
            end
            S_BRK_NL: begin
                char_c     = CH_NEWLINE;
                state_step = S_BODY;
            end
            S_BODY: begin
                if (head_cmd.quoted) begin
                    char_c     = CH_EQUALS;
                    state_step = S_HEX_HI;
                end else begin
                    last_c = 1'b1;
                    done_c = 1'b1;
                end
            end
            S_HEX_HI: begin
                char_c     = hex_char(head_cmd.data[7:4]);
                state_step = S_HEX_LO;
            end
            S_HEX_LO: begin
                char_c = hex_char(head_cmd.data[3:0]);
                last_c = 1'b1;
                done_c = 1'b1;
            end
            default: begin
                state_step = S_HEAD;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (advance) begin
            state_next    = state_step;
            m_tvalid_next = 1'b1;
            m_tdata_next  = char_c;
            m_tlast_next  = last_c;
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_HEAD;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // mid-expansion the word stays at the queue head
    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_HEAD) |-> head_valid)
        else $error("word left queue before its expansion finished");

    // a soft break newline always follows an equals sign
    a_break_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BRK_NL) |-> (m_tvalid_reg && (m_tdata_reg == CH_EQUALS)))
        else $error("soft break newline not preceded by equals");

    // the last character of a word is never an equals sign
    a_last_not_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |-> (m_tdata_reg != CH_EQUALS))
        else $error("word ended on an equals sign");

endmodule

FILE: src/quoted_printable_encoder.sv
// each accepted word is queued; its characters then leave through the output register
// one output character per cycle while a word is queued and the output is not held;
//   characters: plain byte 1, quoted byte 3, soft break 2 more, so 1 to 5 per word
// the output register in the back end sets the pace; a 4-entry queue lets input run ahead
// reset: synchronous active-low aresetn clears line state and queue, limit returns to 76
module quoted_printable_encoder #(
    parameter int unsigned QUEUE_DEPTH = qpe_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,       // line_limit
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  logic       s_axis_tlast,    // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast     // out_last
);
    import qpe_pkg::*;

    logic     push, push_ready, head_valid, pop;
    qpe_cmd_t push_cmd, head_cmd;

    qpe_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    qpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .head_cmd   (head_cmd)
    );

    qpe_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: tb/quoted_printable_encoder_tb.sv
// testbench for the quoted-printable encoder: random and directed bytes checked against a predictor
module quoted_printable_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpe_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } raw_byte_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } qp_char_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;    // end_of_message
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // out_last

    raw_byte_t  raw_bytes_pending[$];
    qp_char_t   qp_chars_due[$];

    // encoder state as the testbench tracks it
    logic [7:0] limit_now = LIMIT_RESET;
    logic [7:0] cur_col = 8'd0;
    logic       trail_blank = 1'b0;

    int  errors = 0;
    int  cycle_count = 0;
    int  tx_gap = 0;
    int  rx_wait = 0;
    int  hold_cnt = 0;
    bit  hold_kick = 1'b0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;

    quoted_printable_encoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
    endfunction

    function automatic void push_char(input logic [7:0] ch);
        qp_char_t e;
        e.ch = ch;
        e.last = 1'b0;
        qp_chars_due.push_back(e);
    endfunction

    // work out the characters one input word produces and advance the line state
    function automatic void encode_qp_byte(input logic [7:0] c, input logic eom);
        logic plain;
        int   grown;
        plain = (c >= CH_PLAIN_LO && c <= CH_PLAIN_MID) ||
                (c >= CH_PLAIN_HI && c <= CH_PLAIN_TOP) ||
                c == CH_TAB || c == CH_NEWLINE;
        if (cur_col >= limit_now || (c == CH_NEWLINE && trail_blank) ||
            (!plain && int'(cur_col) + 3 >= int'(limit_now))) begin
            push_char(CH_EQUALS);
            push_char(CH_NEWLINE);
            cur_col = 8'd0;
            trail_blank = 1'b0;
        end
        if (plain) begin
            push_char(c);
            grown = int'(cur_col) + 1;
            trail_blank = (c == CH_SPACE || c == CH_TAB);
        end else begin
            push_char(CH_EQUALS);
            push_char(hex_digit(c[7:4]));
            push_char(hex_digit(c[3:0]));
            grown = int'(cur_col) + 3;
            trail_blank = 1'b0;
        end
        cur_col = (grown > 255) ? LEN_MAX : 8'(grown);
        if (plain && c == CH_NEWLINE) cur_col = 8'd0;
        qp_chars_due[$].last = 1'b1;
        if (eom) begin
            cur_col = 8'd0;
            trail_blank = 1'b0;
        end
    endfunction

    // sender
    always @(posedge aclk) begin
        raw_byte_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) encode_qp_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (raw_bytes_pending.size() != 0) begin
                    nxt = raw_bytes_pending.pop_front();
                    s_axis_tdata <= nxt.data;
                    s_axis_tlast <= nxt.eom;
                    s_axis_tvalid <= 1'b1;
                    tx_gap = tx_burst ? 0 : $urandom_range(12);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input qp_char_t want);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected ch=%02h last=%0b, got ch=%02h last=%0b",
                     $realtime, what, want.ch, want.last, m_axis_tdata, m_axis_tlast);
    endtask

    // receiver and checker
    always @(posedge aclk) begin
        qp_char_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (qp_chars_due.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected word", want);
                end else begin
                    want = qp_chars_due.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last)
                        report_mismatch("mismatch", want);
                end
                rx_wait = rx_burst ? 0 : $urandom_range(12);
            end
            if (hold_cnt != 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the input side backs up
    always @(posedge aclk) begin
        if (hold_kick) hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic eom);
        raw_byte_t b;
        b.data = c;
        b.eom = eom;
        raw_bytes_pending.push_back(b);
    endtask

    task automatic wait_drained();
        while (raw_bytes_pending.size() != 0 || s_axis_tvalid || qp_chars_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        limit_now = v;
        @(negedge aclk);
    endtask

    // mostly printable text with blanks, newlines and arbitrary bytes mixed in
    task automatic queue_text(input int n, input int nl_pct, input int eom_pct);
        int r;
        logic [7:0] c;
        @(negedge aclk);
        tx_burst = ($urandom_range(3) == 0);
        rx_burst = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < nl_pct) c = CH_NEWLINE;
            else if (r < nl_pct + 10) c = $urandom_range(1) ? CH_SPACE : CH_TAB;
            else if (r < nl_pct + 35) c = 8'($urandom_range(255));
            else c = 8'($urandom_range(126, 33));
            push_byte(c, $urandom_range(99) < eom_pct);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes of the byte classes, blank before newline, at the reset limit
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'h3D, 1'b0);
        push_byte(8'h3E, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h1F, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_NEWLINE, 1'b0);
        push_byte(CH_SPACE, 1'b0);
        push_byte(CH_NEWLINE, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h0D, 1'b1);
        // leave a partial line open across the limit change
        for (int i = 0; i < 6; i++) push_byte(8'h51 + 8'(i), 1'b0);
        wait_drained();

        // limit now below the open line length
        write_limit(8'd4);
        push_byte(8'h61, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(8'h64, 1'b0);
        push_byte(8'h65, 1'b1);
        wait_drained();

        write_limit(8'd3);
        queue_text(20, 8, 8);
        wait_drained();

        // long lines against the widest limit
        write_limit(8'd255);
        queue_text(40, 0, 0);
        wait_drained();

        write_limit(8'd0);
        queue_text(15, 8, 10);
        wait_drained();

        write_limit(8'($urandom_range(40, 5)));
        queue_text(25, 6, 6);
        wait_drained();

        write_limit(8'd2);
        queue_text(15, 8, 10);
        wait_drained();

        // receiver stalls while the sender keeps offering
        write_limit(8'($urandom_range(30, 10)));
        @(negedge aclk);
        hold_kick = 1'b1;
        @(negedge aclk);
        hold_kick = 1'b0;
        queue_text(30, 5, 5);
        wait_drained();

        // sender pauses mid-message until all output is out
        write_limit(8'd4);
        queue_text(15, 5, 0);
        wait_drained();
        queue_text(15, 5, 10);
        wait_drained();

        write_limit(LIMIT_RESET);
        queue_text(20, 5, 5);
        wait_drained();
        repeat (10) @(negedge aclk);

        if (errors == 0 && qp_chars_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
